// File: src/dwc1d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc1d_pkg
// Shared constants, types and floating-point helpers of the depthwise filter.
// ----------------------------------------------------------------------------
package dwc1d_pkg;

  localparam int CHANNELS = 2048;
  localparam int TAPS     = 4;
  localparam int HDEPTH   = TAPS - 1;
  localparam int CH_W     = 11;
  localparam int HALF_W   = 16;
  localparam int HIST_W   = HDEPTH * HALF_W;
  localparam int HIST_AW  = $clog2(CHANNELS);

  localparam logic [HALF_W-1:0] HALF_QNAN = 16'h7E00;
  localparam logic [HALF_W-1:0] HALF_INF  = 16'h7C00;

  typedef logic [HALF_W-1:0] half_t;

  // Unpacked float: value is 1.man[22:0] * 2^exp when no flag is set.
  typedef struct packed {
    logic              nan;
    logic              inf;
    logic              zero;
    logic              sign;
    logic signed [9:0] exp;
    logic [23:0]       man;
  } fu_t;

  // Item leaving the history stage.
  typedef struct packed {
    logic [CH_W-1:0]          ch;
    half_t                    x;
    half_t [TAPS-1:0]         w;
    half_t [HDEPTH-1:0]       h;
  } item_t;

  // Exact product of two fp16 values.
  function automatic fu_t fp_mul16(input half_t a, input half_t b);
    logic [4:0]        ea_f;
    logic [4:0]        eb_f;
    logic [10:0]       ma;
    logic [10:0]       mb;
    logic signed [9:0] ea;
    logic signed [9:0] eb;
    logic              a_nan;
    logic              b_nan;
    logic              a_inf;
    logic              b_inf;
    logic              a_zero;
    logic              b_zero;
    logic [21:0]       p;
    logic [21:0]       pn;
    logic [4:0]        lz;
    fu_t               r;
    ea_f   = a[14:10];
    eb_f   = b[14:10];
    a_nan  = (ea_f == 5'h1F) && (a[9:0] != 10'd0);
    b_nan  = (eb_f == 5'h1F) && (b[9:0] != 10'd0);
    a_inf  = (ea_f == 5'h1F) && (a[9:0] == 10'd0);
    b_inf  = (eb_f == 5'h1F) && (b[9:0] == 10'd0);
    a_zero = (a[14:0] == 15'd0);
    b_zero = (b[14:0] == 15'd0);
    ma     = {(ea_f != 5'd0), a[9:0]};
    mb     = {(eb_f != 5'd0), b[9:0]};
    ea     = (ea_f == 5'd0) ? -10'sd14 : $signed({5'd0, ea_f}) - 10'sd15;
    eb     = (eb_f == 5'd0) ? -10'sd14 : $signed({5'd0, eb_f}) - 10'sd15;
    p      = {11'd0, ma} * {11'd0, mb};
    lz     = 5'd0;
    for (int i = 0; i < 22; i++) begin
      if (p[i]) begin
        lz = 5'(21 - i);
      end
    end
    pn     = p << lz;
    r.sign = a[15] ^ b[15];
    r.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    r.inf  = !r.nan && (a_inf || b_inf);
    r.zero = !r.nan && !r.inf && (p == 22'd0);
    r.exp  = ea + eb + 10'sd1 - $signed({5'd0, lz});
    r.man  = {pn, 2'b00};
    return r;
  endfunction

  // fp32 addition with round-to-nearest-even on unpacked operands.
  function automatic fu_t fp_add(input fu_t a, input fu_t b);
    fu_t               r;
    fu_t               x;
    fu_t               y;
    logic [9:0]        d;
    logic [26:0]       mx;
    logic [26:0]       my;
    logic [26:0]       sh;
    logic [27:0]       s;
    logic [4:0]        lz;
    logic [23:0]       mr;
    logic [24:0]       mrnd;
    logic signed [9:0] e;
    logic              rnd;
    r = a;
    r.nan = 1'b0;
    r.inf = 1'b0;
    r.zero = 1'b0;
    if (a.nan || b.nan || (a.inf && b.inf && (a.sign != b.sign))) begin
      r.nan = 1'b1;
    end else if (a.inf) begin
      r = a;
    end else if (b.inf) begin
      r = b;
    end else if (a.zero && b.zero) begin
      r = a;
      r.sign = a.sign & b.sign;
    end else if (a.zero) begin
      r = b;
    end else if (b.zero) begin
      r = a;
    end else begin
      if ((b.exp > a.exp) || ((b.exp == a.exp) && (b.man > a.man))) begin
        x = b;
        y = a;
      end else begin
        x = a;
        y = b;
      end
      d  = 10'(x.exp - y.exp);
      mx = {x.man, 3'b000};
      my = {y.man, 3'b000};
      if (d > 10'd26) begin
        sh = 27'd1;
      end else begin
        sh = my >> d;
        sh[0] = sh[0] | (|(my & ((27'd1 << d) - 27'd1)));
      end
      if (x.sign ^ y.sign) begin
        s = {1'b0, mx} - {1'b0, sh};
      end else begin
        s = {1'b0, mx} + {1'b0, sh};
      end
      e  = x.exp;
      lz = 5'd0;
      for (int i = 0; i < 27; i++) begin
        if (s[i]) begin
          lz = 5'(26 - i);
        end
      end
      if (s == 28'd0) begin
        r.zero = 1'b1;
        r.sign = 1'b0;
      end else begin
        if (s[27]) begin
          s = {1'b0, s[27:2], s[1] | s[0]};
          e = e + 10'sd1;
        end else begin
          s = s << lz;
          e = e - $signed({5'd0, lz});
        end
        mr   = s[26:3];
        rnd  = s[2] & ((|s[1:0]) | mr[0]);
        mrnd = {1'b0, mr} + {24'd0, rnd};
        if (mrnd[24]) begin
          mr = 24'h800000;
          e  = e + 10'sd1;
        end else begin
          mr = mrnd[23:0];
        end
        r.sign = x.sign;
        r.exp  = e;
        r.man  = mr;
      end
    end
    return r;
  endfunction

  // Round an unpacked value to fp16, nearest even.
  function automatic half_t fp_to_half(input fu_t a);
    half_t             res;
    logic signed [9:0] sft_s;
    logic [4:0]        sft;
    logic [10:0]       keep;
    logic [23:0]       rem;
    logic [23:0]       halfp;
    logic              rnd;
    sft_s = -10'sd1 - a.exp;
    sft   = sft_s[4:0];
    keep  = a.man[23:13];
    rnd   = 1'b0;
    if (a.nan) begin
      res = HALF_QNAN;
    end else if (a.inf || (!a.zero && (a.exp > 10'sd15))) begin
      res = {a.sign, 15'd0} | HALF_INF;
    end else if (a.zero) begin
      res = {a.sign, 15'd0};
    end else if (a.exp >= -10'sd14) begin
      rnd = (a.man[12:0] > 13'h1000) || ((a.man[12:0] == 13'h1000) && keep[0]);
      res = {a.sign, 15'd0} | ((16'(a.exp + 10'sd14) << 10) + {5'd0, keep}
                               + {15'd0, rnd});
    end else if (sft_s >= 10'sd25) begin
      res = {a.sign, 15'd0};
    end else begin
      keep  = 11'(a.man >> sft);
      rem   = a.man & ((24'd1 << sft) - 24'd1);
      halfp = 24'd1 << (sft - 5'd1);
      rnd   = (rem > halfp) || ((rem == halfp) && keep[0]);
      res   = {a.sign, 15'd0} | ({5'd0, keep} + {15'd0, rnd});
    end
    return res;
  endfunction

endpackage

// File: src/dwc1d_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc1d_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dwc1d_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/dwc1d_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc1d_hist
// History fetch stage: reads, forwards and updates the per-channel history.
// ----------------------------------------------------------------------------
module dwc1d_hist
  import dwc1d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            valid,
  output logic            stall,
  input  logic [CH_W-1:0] channel,
  input  half_t           sample,
  input  half_t           weight_tap0,
  input  half_t           weight_tap1,
  input  half_t           weight_tap2,
  input  half_t           weight_tap3,
  output logic            item_valid,
  output item_t           item,
  input  logic            item_ready
);

  logic                     clr;
  logic [HIST_AW-1:0]       clr_idx;
  logic                     v1;
  logic [CH_W-1:0]          ch1;
  logic                     inr1;
  half_t                    x1;
  half_t [TAPS-1:0]         w1;
  logic                     byp1;
  logic [HIST_W-1:0]        bypd1;
  logic [HIST_W-1:0]        rdata;
  half_t [HDEPTH-1:0]       hcur;
  half_t [HDEPTH-1:0]       hnew;
  logic                     acc;
  logic                     upd;
  logic                     wr_en;
  logic [HIST_AW-1:0]       wr_addr;
  logic [HIST_W-1:0]        wr_data;
  logic                     in_rng;

  assign in_rng = {1'b0, channel} < (CH_W + 1)'(CHANNELS);
  assign stall  = clr || (v1 && !item_ready);
  assign acc    = valid && !stall;

  assign hcur = !inr1 ? '0 : (byp1 ? bypd1 : rdata);
  assign hnew = {x1, hcur[HDEPTH-1:1]};
  assign upd  = v1 && item_ready && inr1;

  always_comb begin
    if (clr) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = '0;
    end else begin
      wr_en   = upd;
      wr_addr = ch1[HIST_AW-1:0];
      wr_data = hnew;
    end
  end

  dwc1d_ram #(
    .WIDTH (HIST_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (acc),
    .rd_addr (channel[HIST_AW-1:0]),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr     <= 1'b1;
      clr_idx <= '0;
      v1      <= 1'b0;
    end else begin
      if (clr) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == HIST_AW'(CHANNELS - 1)) begin
          clr <= 1'b0;
        end
      end
      if (acc) begin
        v1 <= 1'b1;
      end else if (item_ready) begin
        v1 <= 1'b0;
      end
    end
  end

  // A write landing on the same edge as the read is forwarded to the new item.
  always_ff @(posedge clk) begin
    if (acc) begin
      ch1   <= channel;
      inr1  <= in_rng;
      x1    <= sample;
      w1    <= {weight_tap3, weight_tap2, weight_tap1, weight_tap0};
      byp1  <= upd && (ch1[HIST_AW-1:0] == channel[HIST_AW-1:0]);
      bypd1 <= hnew;
    end
  end

  assign item_valid = v1;
  assign item.ch    = ch1;
  assign item.x     = x1;
  assign item.w     = w1;
  assign item.h     = hcur;

endmodule

// File: src/dwc1d_arith.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwc1d_arith
// Product, three accumulate and fp16 rounding stages with an output register.
// ----------------------------------------------------------------------------
module dwc1d_arith
  import dwc1d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  item_t           item,
  output logic            item_ready,
  output logic            valid,
  input  logic            stall,
  output logic [CH_W-1:0] out_channel,
  output half_t           conv_out
);

  logic            v2;
  logic            v3;
  logic            v4;
  logic            v5;
  logic            v6;
  logic            r2;
  logic            r3;
  logic            r4;
  logic            r5;
  logic            r6;
  logic [CH_W-1:0] ch2;
  logic [CH_W-1:0] ch3;
  logic [CH_W-1:0] ch4;
  logic [CH_W-1:0] ch5;
  fu_t [TAPS-1:0]  p2;
  fu_t             a3;
  fu_t             p3_2;
  fu_t             p3_3;
  fu_t             a4;
  fu_t             p4_3;
  fu_t             a5;
  fu_t             p0;

  assign r6 = !v6 || !stall;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign item_ready = r2;

  // The sum starts at +0, so a lone negative zero product turns positive.
  always_comb begin
    p0 = fp_mul16(item.w[0], item.h[0]);
    if (p0.zero) begin
      p0.sign = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r2) v2 <= item_valid;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (r2) begin
      ch2   <= item.ch;
      p2[0] <= p0;
      p2[1] <= fp_mul16(item.w[1], item.h[1]);
      p2[2] <= fp_mul16(item.w[2], item.h[2]);
      p2[3] <= fp_mul16(item.w[3], item.x);
    end
    if (r3) begin
      ch3  <= ch2;
      a3   <= fp_add(p2[0], p2[1]);
      p3_2 <= p2[2];
      p3_3 <= p2[3];
    end
    if (r4) begin
      ch4  <= ch3;
      a4   <= fp_add(a3, p3_2);
      p4_3 <= p3_3;
    end
    if (r5) begin
      ch5 <= ch4;
      a5  <= fp_add(a4, p4_3);
    end
    if (r6) begin
      out_channel <= ch5;
      conv_out    <= fp_to_half(a5);
    end
  end

  assign valid = v6;

endmodule

// File: src/causal_depthwise_conv1d_step_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// causal_depthwise_conv1d_step_top
// Per-channel causal four-tap fp16 filter for one decode step.
// ----------------------------------------------------------------------------
// After reset the block clears the history memory, one channel per cycle, and
// holds stall high meanwhile. From then on it takes one item per cycle while
// the output is not stalled. The history memory is read at the transfer edge
// itself. After that come the four exact products and then three fp32
// additions (taken in tap order). Last comes the fp16 rounding, which lands
// in the output register. Items for the same channel may follow each other
// in consecutive cycles; the freshly written history is forwarded.
// A stalled output freezes only the stages that are full, so bubbles collapse
// and input transfers continue until the pipeline is filled.
// ----------------------------------------------------------------------------
module causal_depthwise_conv1d_step_top
  import dwc1d_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [CH_W-1:0] channel,
  input  logic [15:0]     sample,
  input  logic [15:0]     weight_tap0,
  input  logic [15:0]     weight_tap1,
  input  logic [15:0]     weight_tap2,
  input  logic [15:0]     weight_tap3,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [CH_W-1:0] out_channel,
  output logic [15:0]     conv_out
);

  logic  item_valid;
  logic  item_ready;
  item_t item;

  // Stage one: history read, same-channel forwarding and history update.
  dwc1d_hist u_hist (
    .clk         (clk),
    .rst         (rst),
    .valid       (in_valid),
    .stall       (in_stall),
    .channel     (channel),
    .sample      (sample),
    .weight_tap0 (weight_tap0),
    .weight_tap1 (weight_tap1),
    .weight_tap2 (weight_tap2),
    .weight_tap3 (weight_tap3),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready)
  );

  // Stages two to six: products, ordered accumulation and rounding.
  dwc1d_arith u_arith (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item        (item),
    .item_ready  (item_ready),
    .valid       (out_valid),
    .stall       (out_stall),
    .out_channel (out_channel),
    .conv_out    (conv_out)
  );

endmodule
